// ===== hw/rtl/scale3x_pixel_art_upscaler_defines.svh =====
// Assertion macros used by the checker of the upscaler.
`ifndef SCALE3X_PIXEL_ART_UPSCALER_DEFINES_SVH
`define SCALE3X_PIXEL_ART_UPSCALER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define S3X_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s3x check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define S3X_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s3x check failed");

`endif

// ===== hw/rtl/s3x_pkg.sv =====
package s3x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W = 32;
    localparam int LEN_W = 11;
    localparam int COL_W = $clog2(MAX_WIDTH);

    localparam logic [LEN_W-1:0] LINE_WIDTH_RESET   = LEN_W'(320);
    localparam logic [LEN_W-1:0] FRAME_HEIGHT_RESET = LEN_W'(200);
    localparam logic [LEN_W-1:0] MAX_WIDTH_LEN      = LEN_W'(MAX_WIDTH);
    localparam logic [LEN_W-1:0] MAX_HEIGHT_LEN     = LEN_W'(MAX_HEIGHT);

    // Input word kinds on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // Index 0 top, 1 middle, 2 bottom
    typedef logic [2:0][PIX_W-1:0] column_t;

    // Last member lands in the lowest bits
    typedef struct packed {
        pixel_t bot_right;
        pixel_t bot_mid;
        pixel_t bot_left;
        pixel_t mid_right;
        pixel_t centre_px;
        pixel_t mid_left;
        pixel_t top_right;
        pixel_t top_mid;
        pixel_t top_left;
    } blk_t;

endpackage

// ===== hw/rtl/s3x_ram.sv =====
module s3x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/s3x_rule.sv =====
module s3x_rule (
    input  s3x_pkg::column_t lcol,
    input  s3x_pkg::column_t mcol,
    input  s3x_pkg::column_t rcol,
    output s3x_pkg::blk_t    blk
);

    import s3x_pkg::*;

    pixel_t p_a, p_b, p_c, p_d, p_e, p_f, p_g, p_h, p_i;
    logic   db, bf, hd, fh;

    assign p_a = lcol[0];
    assign p_d = lcol[1];
    assign p_g = lcol[2];
    assign p_b = mcol[0];
    assign p_e = mcol[1];
    assign p_h = mcol[2];
    assign p_c = rcol[0];
    assign p_f = rcol[1];
    assign p_i = rcol[2];

    // Edge matches around the centre
    assign db = (p_d == p_b) && (p_d != p_h) && (p_b != p_f);
    assign bf = (p_b == p_f) && (p_b != p_d) && (p_f != p_h);
    assign hd = (p_h == p_d) && (p_h != p_f) && (p_d != p_b);
    assign fh = (p_f == p_h) && (p_f != p_b) && (p_h != p_d);

    always_comb
    begin
        blk.top_left  = db ? p_d : p_e;
        blk.top_mid   = ((db && (p_e != p_c)) || (bf && (p_e != p_a))) ? p_b : p_e;
        blk.top_right = bf ? p_f : p_e;
        blk.mid_left  = ((hd && (p_e != p_a)) || (db && (p_e != p_g))) ? p_d : p_e;
        blk.centre_px = p_e;
        blk.mid_right = ((bf && (p_e != p_i)) || (fh && (p_e != p_c))) ? p_f : p_e;
        blk.bot_left  = hd ? p_d : p_e;
        blk.bot_mid   = ((fh && (p_e != p_g)) || (hd && (p_e != p_i))) ? p_h : p_e;
        blk.bot_right = fh ? p_f : p_e;
    end

endmodule

// ===== hw/rtl/scale3x_pixel_art_upscaler.sv =====
// 3x pixel-art upscaler (scale3x rules), one source pixel per word.
// Input stream: tdata carries the 32-bit pixel, tuser the word kind (pixel or
// bottom flush). Send line_width x frame_height pixels in raster order, then
// one flush word per column to produce the bottom row of blocks.
// Output stream: each word is one 3x3 block of pixels; tlast marks the final
// block caused by an input word, tuser marks the frame's bottom-right block.
// Blocks lag their source by one row and one column; the last pixel of a row
// also yields the right-edge block, so such a word gives two blocks.
// A block passes the working stage, then the output register; a second
// block from the same word follows. Throughput: one word per cycle while the
// output is not stalled; a word that yields two blocks holds the input while
// the second block goes out through the single output register. Line stores
// are simple dual-port RAMs read one word ahead, with write-to-read
// forwarding for the same column.
// Words of the wrong kind (flush while rows are due, pixel during the flush
// phase) are taken and dropped. Reset clears counters and valid flags and
// restores line_width 320, frame_height 200. A stalled receiver holds the
// output word; input is taken while the pending block register has room.
// APB: line_width at 0x0, frame_height at 0x4; write only while idle.
module scale3x_pixel_art_upscaler (
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Source pixels
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  s3x_pkg::pixel_t     s_axis_tdata,   // [31:0] pixel
    input  logic                s_axis_tuser,   // [0] opcode
    // Output blocks
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output s3x_pkg::blk_t       m_axis_tdata,   // top_left, top_mid, top_right, mid_left,
                                                // centre_px, mid_right, bot_left, bot_mid,
                                                // bot_right, 32 bits each
    output logic                m_axis_tlast,   // last_of_run
    output logic                m_axis_tuser    // [0] frame_end
);

    import s3x_pkg::*;

    // Configuration
    logic [LEN_W-1:0] lw_reg, fh_reg;
    logic [LEN_W-1:0] w_eff, h_eff;
    logic             cfg_wr;

    // Frame position
    logic [COL_W-1:0] col_cnt_reg;
    logic [LEN_W-1:0] row_cnt_reg;
    logic             in_acc, in_flush, flush_phase, take, lastcol;

    // Working stage
    logic             s1_valid_reg, s1_phase_reg, s1_flush_reg, s1_row0_reg, s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    pixel_t           s1_px_reg;
    logic             has1, has2, cur_is2, need_out, out_free, step, s1_final;

    // Line stores
    pixel_t           above_q, centre_q, above_rd, centre_rd;
    pixel_t           wr_above, wr_centre;
    logic             st_we;
    logic             fwd_reg;
    pixel_t           fwd_above_reg, fwd_centre_reg;

    // Window
    column_t          win0_reg, win1_reg, cur_col, l2col;
    blk_t             blk1, blk2;

    // Output register
    logic             out_valid_reg, out_last_reg, out_fend_reg;
    blk_t             out_blk_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg <= LINE_WIDTH_RESET;
            fh_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_LINE_WIDTH:   lw_reg <= pwdata[LEN_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LINE_WIDTH:   prdata = {{(32-LEN_W){1'b0}}, lw_reg};
            REG_FRAME_HEIGHT: prdata = {{(32-LEN_W){1'b0}}, fh_reg};
            default:          prdata = '0;
        endcase
    end

    // Zero acts as one, oversize clamps to MAX_WIDTH or MAX_HEIGHT
    always_comb
    begin
        if (lw_reg == '0)
            w_eff = LEN_W'(1);
        else if (lw_reg > MAX_WIDTH_LEN)
            w_eff = MAX_WIDTH_LEN;
        else
            w_eff = lw_reg;

        if (fh_reg == '0)
            h_eff = LEN_W'(1);
        else if (fh_reg > MAX_HEIGHT_LEN)
            h_eff = MAX_HEIGHT_LEN;
        else
            h_eff = fh_reg;
    end

    // ---------------- input and counters ----------------
    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign in_flush    = (s_axis_tuser == OP_FLUSH);
    assign flush_phase = (row_cnt_reg >= h_eff);
    assign take        = in_acc && (in_flush == flush_phase);
    assign lastcol     = (({1'b0, col_cnt_reg} + LEN_W'(1)) >= w_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (take)
        begin
            if (lastcol)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= in_flush ? '0 : row_cnt_reg + LEN_W'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + COL_W'(1);
            end
        end
    end

    // ---------------- working stage control ----------------
    assign has1     = !s1_row0_reg && (s1_col_reg != '0);
    assign has2     = !s1_row0_reg && s1_last_reg;
    assign cur_is2  = s1_phase_reg || !has1;
    assign need_out = cur_is2 ? has2 : 1'b1;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign step     = s1_valid_reg && (!need_out || out_free);
    // finish once the block going out now is the word's last one
    assign s1_final = step && (cur_is2 || !has2);

    assign s_axis_tready = !s1_valid_reg || s1_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (s1_final)
                s1_valid_reg <= 1'b0;

            if (s1_final)
                s1_phase_reg <= 1'b0;
            else if (step)
                s1_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_px_reg    <= s_axis_tdata;
            s1_flush_reg <= in_flush;
            s1_row0_reg  <= !in_flush && (row_cnt_reg == '0);
            s1_last_reg  <= lastcol;
            s1_col_reg   <= col_cnt_reg;
            // forward a same-column write that lands on this read edge
            fwd_reg        <= st_we && (s1_col_reg == col_cnt_reg);
            fwd_above_reg  <= wr_above;
            fwd_centre_reg <= wr_centre;
        end
    end

    // ---------------- line stores ----------------
    assign above_rd  = fwd_reg ? fwd_above_reg : above_q;
    assign centre_rd = fwd_reg ? fwd_centre_reg : centre_q;
    assign st_we     = s1_final && !s1_flush_reg;
    assign wr_above  = s1_row0_reg ? s1_px_reg : centre_rd;
    assign wr_centre = s1_px_reg;

    s3x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
        .clk   (clk),
        .we    (st_we),
        .waddr (s1_col_reg),
        .wdata (wr_above),
        .re    (take),
        .raddr (col_cnt_reg),
        .rdata (above_q)
    );

    s3x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_centre (
        .clk   (clk),
        .we    (st_we),
        .waddr (s1_col_reg),
        .wdata (wr_centre),
        .re    (take),
        .raddr (col_cnt_reg),
        .rdata (centre_q)
    );

    // ---------------- window ----------------
    always_comb
    begin
        if (s1_flush_reg)
        begin
            cur_col[0] = above_rd;
            cur_col[1] = centre_rd;
            cur_col[2] = centre_rd;
        end
        else if (s1_row0_reg)
        begin
            cur_col[0] = s1_px_reg;
            cur_col[1] = s1_px_reg;
            cur_col[2] = s1_px_reg;
        end
        else
        begin
            cur_col[0] = above_rd;
            cur_col[1] = centre_rd;
            cur_col[2] = s1_px_reg;
        end
    end

    // Right-edge block: on the first column the window restarts from this column
    assign l2col = (s1_col_reg == '0) ? cur_col : win1_reg;

    always_ff @(posedge clk)
    begin
        if (s1_final)
        begin
            win0_reg <= l2col;
            win1_reg <= cur_col;
        end
    end

    s3x_rule u_rule_main (
        .lcol (win0_reg),
        .mcol (win1_reg),
        .rcol (cur_col),
        .blk  (blk1)
    );

    s3x_rule u_rule_edge (
        .lcol (l2col),
        .mcol (cur_col),
        .rcol (cur_col),
        .blk  (blk2)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && need_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && need_out)
        begin
            out_blk_reg  <= cur_is2 ? blk2 : blk1;
            out_last_reg <= cur_is2 ? 1'b1 : !s1_last_reg;
            out_fend_reg <= cur_is2 && s1_flush_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_blk_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_fend_reg;

endmodule

// ===== hw/rtl/s3x_checker.sv =====
`include "scale3x_pixel_art_upscaler_defines.svh"

module s3x_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            psel,
    input logic            penable,
    input logic            pwrite,
    input logic [2:0]      paddr,
    input logic [31:0]     pwdata,
    input logic [31:0]     prdata,
    input logic            pready,
    input logic            s_axis_tvalid,
    input logic            s_axis_tready,
    input s3x_pkg::pixel_t s_axis_tdata,
    input logic            s_axis_tuser,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input s3x_pkg::blk_t   m_axis_tdata,
    input logic            m_axis_tlast,
    input logic            m_axis_tuser
);

    import s3x_pkg::*;

    // Hold a stalled output word
    `S3X_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // The frame's final block is always the last block of its word
    `S3X_ASSERT_NOW(a_fend_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // Registers read back as 11-bit values
    `S3X_ASSERT_NOW(a_prdata_narrow, psel && !pwrite, prdata[31:LEN_W] == '0)

    // A register write is visible on the next read of the same address
    `S3X_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready,
        (paddr[2] != $past(paddr[2])) || (prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0])))

endmodule

bind scale3x_pixel_art_upscaler s3x_checker u_s3x_checker (.*);
